// ----- rtl/core/cptm_pkg.sv -----
`timescale 1ns / 1ps
// Shared types for the control period timing monitor.
// No dependencies; imported by the interfaces, the classifier and the top level.
package cptm_pkg;

    typedef enum logic [2:0] {
        ST_FIRST  = 3'd0,
        ST_EARLY  = 3'd1,
        ST_NORMAL = 3'd2,
        ST_LATE   = 3'd3,
        ST_MISSED = 3'd4
    } t_status;

    typedef struct packed {
        logic [31:0] now_ms;
    } t_in_item;

    typedef struct packed {
        t_status     timing_status;
        logic [31:0] step_dt_ms;
        logic [31:0] missed_total;
        logic [31:0] late_total;
    } t_out_item;

    // Decision for one timestamp, handed from the classifier to the state registers.
    typedef struct packed {
        t_status     status;
        logic [31:0] dt_ms;
        logic        set_started;
        logic        ref_update;
        logic        miss_inc;
        logic        late_inc;
    } t_step_ctl;

    localparam logic [31:0] PERIOD_RESET = 32'd10;

endpackage

// ----- rtl/core/cptm_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channels for timestamps in and classified steps out.
// Depends on cptm_pkg for the payload structs.
interface cptm_in_if import cptm_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface cptm_out_if import cptm_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/core/cptm_classify.sv -----
`timescale 1ns / 1ps
// Step classifier: elapsed time and the three period comparisons for one timestamp.
// Depends on cptm_pkg for t_step_ctl and t_status.
module cptm_classify import cptm_pkg::*; (
    input  logic [31:0] i_period,
    input  logic        i_started,
    input  logic [31:0] i_ref_ms,
    input  logic [31:0] i_now_ms,
    output t_step_ctl   o_ctl
);

    logic [31:0] elapsed;
    logic [32:0] elapsed_x2;
    logic [32:0] period_x2;
    logic [33:0] period_x3;
    logic        is_early;
    logic        is_missed;
    logic        is_late;

    assign elapsed    = i_now_ms - i_ref_ms;
    assign elapsed_x2 = {elapsed, 1'b0};
    assign period_x2  = {i_period, 1'b0};
    assign period_x3  = {1'b0, period_x2} + {2'b00, i_period};

    assign is_early  = elapsed_x2 < {1'b0, i_period};
    assign is_missed = {1'b0, elapsed} > period_x2;
    assign is_late   = {1'b0, elapsed_x2} > period_x3;

    always_comb begin
        o_ctl = '{status: ST_MISSED, dt_ms: '0, set_started: 1'b0,
                  ref_update: 1'b0, miss_inc: 1'b0, late_inc: 1'b0};
        if (i_period == '0) begin
            // zero period: report missed, touch nothing
            o_ctl.status = ST_MISSED;
        end else if (!i_started) begin
            o_ctl.status      = ST_FIRST;
            o_ctl.set_started = 1'b1;
            o_ctl.ref_update  = 1'b1;
        end else if (is_early) begin
            o_ctl.status = ST_EARLY;
        end else if (is_missed) begin
            o_ctl.status     = ST_MISSED;
            o_ctl.ref_update = 1'b1;
            o_ctl.miss_inc   = 1'b1;
        end else if (is_late) begin
            o_ctl.status     = ST_LATE;
            o_ctl.dt_ms      = elapsed;
            o_ctl.ref_update = 1'b1;
            o_ctl.late_inc   = 1'b1;
        end else begin
            o_ctl.status     = ST_NORMAL;
            o_ctl.dt_ms      = elapsed;
            o_ctl.ref_update = 1'b1;
        end
    end

endmodule

// ----- rtl/core/control_period_timing_monitor.sv -----
`timescale 1ns / 1ps
// Top level of the control period timing monitor: state registers and output stage.
// Depends on cptm_pkg, cptm_if and cptm_classify.
//
// Usage:
//   i_in carries one millisecond timestamp per control step; o_out returns one
//   classified step per timestamp (status, elapsed ms, miss and late totals).
//   i_cfg_we / i_cfg_wdata write the nominal period; write it only while idle.
//   The result is registered: a timestamp transferred on i_in is offered on
//   o_out in the next cycle. Throughput is one item per cycle while o_out is not
//   stalled; the elapsed-time subtract and three comparisons against the period
//   set the cycle, and the reference register feeds the next item directly.
//   The single output register takes a new result whenever it is empty or its
//   content is taken in the same cycle, so i_in.ready follows o_out.ready while
//   a result is held; a stalled receiver stalls the input after one item.
//   Reset (synchronous, active low) clears the started flag, reference time and
//   both counters, sets the period to 10 ms and empties the output register.
module control_period_timing_monitor import cptm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    cptm_in_if.sink     i_in,
    cptm_out_if.source  o_out
);

    logic [31:0] r_period;
    logic        r_started;
    logic [31:0] r_ref_ms;
    logic [31:0] r_miss_cnt;
    logic [31:0] r_late_cnt;
    logic        r_out_valid;
    t_out_item   r_out;

    logic [31:0] n_miss_cnt;
    logic [31:0] n_late_cnt;
    logic        in_xfer;
    t_step_ctl   step_ctl;

    cptm_classify u_classify (
        .i_period  (r_period),
        .i_started (r_started),
        .i_ref_ms  (r_ref_ms),
        .i_now_ms  (i_in.payload.now_ms),
        .o_ctl     (step_ctl)
    );

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_xfer    = i_in.valid && i_in.ready;

    assign n_miss_cnt = r_miss_cnt + {31'd0, step_ctl.miss_inc};
    assign n_late_cnt = r_late_cnt + {31'd0, step_ctl.late_inc};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RESET;
        end else if (i_cfg_we) begin
            r_period <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started  <= 1'b0;
            r_ref_ms   <= '0;
            r_miss_cnt <= '0;
            r_late_cnt <= '0;
        end else if (in_xfer) begin
            if (step_ctl.set_started) begin
                r_started <= 1'b1;
            end
            if (step_ctl.ref_update) begin
                r_ref_ms <= i_in.payload.now_ms;
            end
            r_miss_cnt <= n_miss_cnt;
            r_late_cnt <= n_late_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // payload holds while stalled; load only on a transfer
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_out.timing_status <= step_ctl.status;
            r_out.step_dt_ms    <= step_ctl.dt_ms;
            r_out.missed_total  <= n_miss_cnt;
            r_out.late_total    <= n_late_cnt;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    a_miss_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_miss_cnt != $past(r_miss_cnt))
            |-> (r_miss_cnt == $past(r_miss_cnt) + 32'd1))
        else $error("miss counter moved by other than one");

    a_late_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_late_cnt != $past(r_late_cnt))
            |-> (r_late_cnt == $past(r_late_cnt) + 32'd1))
        else $error("late counter moved by other than one");

    a_xfer_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> r_out_valid)
        else $error("accepted step produced no result");

    a_dt_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.step_dt_ms != 32'd0)
            |-> (r_out.timing_status == ST_NORMAL || r_out.timing_status == ST_LATE))
        else $error("elapsed time reported for a step that is not normal or late");

endmodule
